[design/edcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package edcs_pkg;

	localparam int NUM_SLOTS_DEF = 128;

	localparam int SLOT_W = 7;
	localparam int DL_W   = 16;
	localparam int ADDR_W = 32;
	localparam int LEN_W  = 31;
	localparam int DIR_W  = 2;
	localparam int DESC_W = DIR_W + LEN_W + ADDR_W + ADDR_W;

	typedef enum logic [1:0] {
		REQ_POST     = 2'd0,
		REQ_DISPATCH = 2'd1,
		REQ_COMPLETE = 2'd2,
		REQ_SYNC     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_FREE    = 2'd0,
		ST_PENDING = 2'd1,
		ST_RUNNING = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_READ
	} fsm_t;

	// broadcast command to all cells, qualified by each cell's select
	typedef struct packed {
		logic            post;
		logic            complete;
		logic            run;
		logic [DL_W-1:0] dl;
	} cmd_t;

	// partial search result handed from cell to cell
	typedef struct packed {
		logic            have;
		logic            hit;
		logic [DL_W-1:0] best_dl;
	} link_t;

endpackage

`default_nettype wire

[design/edcs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module edcs_cell #(
	parameter int IDX_W = 7,
	parameter int INDEX = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    sel,
	input  wire edcs_pkg::cmd_t    cmd,
	input  wire [edcs_pkg::DL_W-1:0] query_dl,
	input  wire edcs_pkg::link_t   link_in,
	input  wire [IDX_W-1:0]        idx_in,
	output edcs_pkg::link_t        link_out,
	output logic [IDX_W-1:0]       idx_out
);
	import edcs_pkg::*;

	status_t         status_q;
	logic [DL_W-1:0] dl_q;
	logic            take;
	logic            live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_FREE;
		end else if (sel) begin
			if (cmd.post) begin
				status_q <= ST_PENDING;
			end else if (cmd.run) begin
				status_q <= ST_RUNNING;
			end else if (cmd.complete && status_q != ST_FREE) begin
				status_q <= ST_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.post) begin
			dl_q <= cmd.dl;
		end
	end

	// strict less-than keeps the lower index on ties
	assign take = (status_q == ST_PENDING) && (!link_in.have || dl_q < link_in.best_dl);
	assign live = (status_q == ST_PENDING) || (status_q == ST_RUNNING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_out <= '0;
			idx_out  <= '0;
		end else begin
			link_out.have    <= link_in.have | take;
			link_out.hit     <= link_in.hit | (live && dl_q == query_dl);
			link_out.best_dl <= take ? dl_q : link_in.best_dl;
			idx_out          <= take ? IDX_W'(INDEX) : idx_in;
		end
	end

endmodule

`default_nettype wire

[design/edcs_desc_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module edcs_desc_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int W     = 97
) (
	input  wire          clk,
	input  wire          wr_en,
	input  wire [AW-1:0] wr_addr,
	input  wire [W-1:0]  wr_data,
	input  wire          rd_en,
	input  wire [AW-1:0] rd_addr,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[design/earliest_deadline_copy_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none

// earliest-deadline copy scheduler
// input channel: in_valid / in_stall carry one request (post, dispatch,
// complete, sync) with its descriptor fields; output channel: out_valid /
// out_stall carry exactly one result per request, in request order.
// slot status and deadlines live in a row of NUM_SLOTS cells; a search
// result ripples one cell per cycle down the row. descriptors sit in a
// single-port-write, registered-read memory.
// post and complete load the output register at the transfer, sync and a
// dispatch that finds nothing pending once the search has crossed the row,
// a dispatch that finds a task after the row and the descriptor read. one
// request is in flight at a time: post and complete can follow every cycle
// unless the receiver stalls; a search holds in_stall until its result loads.
// the result sits in an output register; while the receiver stalls it
// holds, and in_stall stays high until that result is taken or leaves in
// the same cycle as the next transfer.
// reset marks every slot free and empties the output register; no
// clearing pass is needed.
module earliest_deadline_copy_scheduler #(
	parameter int NUM_SLOTS = edcs_pkg::NUM_SLOTS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [1:0]                  req_type,
	input  wire [edcs_pkg::SLOT_W-1:0] slot,
	input  wire [edcs_pkg::DL_W-1:0]   deadline,
	input  wire [edcs_pkg::ADDR_W-1:0] src_addr,
	input  wire [edcs_pkg::ADDR_W-1:0] dst_addr,
	input  wire [edcs_pkg::LEN_W-1:0]  byte_count,
	input  wire [edcs_pkg::DIR_W-1:0]  direction,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       found,
	output logic [edcs_pkg::SLOT_W-1:0] out_slot,
	output logic [edcs_pkg::DL_W-1:0]  out_deadline,
	output logic [edcs_pkg::ADDR_W-1:0] out_src_addr,
	output logic [edcs_pkg::ADDR_W-1:0] out_dst_addr,
	output logic [edcs_pkg::LEN_W-1:0] out_byte_count,
	output logic [edcs_pkg::DIR_W-1:0] out_direction,
	output logic                       sync_pending
);
	import edcs_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	fsm_t             state_q, state_d;
	req_t             req_q;
	logic [DL_W-1:0]  qdl_q;
	logic [DL_W-1:0]  query_dl;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [DL_W-1:0]  best_dl_q;

	logic             accept;
	logic             in_range;
	logic [CW-1:0]    slot_ext;
	logic [IDX_W-1:0] slot_idx;
	logic             done;
	cmd_t             cmd;
	logic [IDX_W-1:0] cmd_idx;
	logic [NUM_SLOTS-1:0] sel;

	link_t            link_w [0:NUM_SLOTS];
	logic [IDX_W-1:0] idx_w  [0:NUM_SLOTS];

	logic             rd_en;
	logic [DESC_W-1:0] rd_data;
	logic [DESC_W-1:0] wr_data;

	logic             out_load;
	logic             nxt_found;
	logic [SLOT_W-1:0] nxt_slot;
	logic [DL_W-1:0]  nxt_dl;
	logic [ADDR_W-1:0] nxt_src;
	logic [ADDR_W-1:0] nxt_dst;
	logic [LEN_W-1:0] nxt_len;
	logic [DIR_W-1:0] nxt_dir;
	logic             nxt_sync;

	logic             out_valid_q;
	logic             found_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [DL_W-1:0]  out_dl_q;
	logic [ADDR_W-1:0] out_src_q;
	logic [ADDR_W-1:0] out_dst_q;
	logic [LEN_W-1:0] out_len_q;
	logic [DIR_W-1:0] out_dir_q;
	logic             sync_q;

	assign in_stall = (state_q != FSM_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(slot) < NUM_SLOTS);
	assign slot_ext = CW'(slot);
	assign slot_idx = slot_ext[IDX_W-1:0];
	assign done     = (state_q == FSM_SCAN) && (cnt_q == IDX_W'(NUM_SLOTS - 1));

	assign cmd_idx  = (state_q == FSM_IDLE) ? slot_idx : idx_w[NUM_SLOTS];
	assign wr_data  = {direction, byte_count, dst_addr, src_addr};

	// the first cell compares on the transfer edge, before qdl_q holds the query
	assign query_dl = (state_q == FSM_IDLE) ? deadline : qdl_q;

	assign link_w[0] = '0;
	assign idx_w[0]  = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		assign sel[i] = (cmd_idx == IDX_W'(i));
		edcs_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.sel      (sel[i]),
			.cmd      (cmd),
			.query_dl (query_dl),
			.link_in  (link_w[i]),
			.idx_in   (idx_w[i]),
			.link_out (link_w[i+1]),
			.idx_out  (idx_w[i+1])
		);
	end

	edcs_desc_mem #(
		.DEPTH (NUM_SLOTS),
		.AW    (IDX_W),
		.W     (DESC_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (cmd.post),
		.wr_addr (slot_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_w[NUM_SLOTS]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.post     = 1'b0;
		cmd.complete = 1'b0;
		cmd.run      = 1'b0;
		cmd.dl       = deadline;
		rd_en        = 1'b0;
		out_load     = 1'b0;
		nxt_found    = 1'b0;
		nxt_slot     = '0;
		nxt_dl       = '0;
		nxt_src      = '0;
		nxt_dst      = '0;
		nxt_len      = '0;
		nxt_dir      = '0;
		nxt_sync     = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (req_t'(req_type))
						REQ_POST: begin
							cmd.post = in_range;
							out_load = 1'b1;
						end
						REQ_COMPLETE: begin
							cmd.complete = in_range;
							out_load     = 1'b1;
						end
						default: begin
							state_d = FSM_SCAN;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				if (done) begin
					if (req_q == REQ_SYNC) begin
						out_load = 1'b1;
						nxt_sync = link_w[NUM_SLOTS].hit;
						state_d  = FSM_IDLE;
					end else if (link_w[NUM_SLOTS].have) begin
						cmd.run = 1'b1;
						rd_en   = 1'b1;
						state_d = FSM_READ;
					end else begin
						out_load = 1'b1;
						state_d  = FSM_IDLE;
					end
				end
			end
			FSM_READ: begin
				out_load  = 1'b1;
				nxt_found = 1'b1;
				nxt_slot  = SLOT_W'(best_idx_q);
				nxt_dl    = best_dl_q;
				{nxt_dir, nxt_len, nxt_dst, nxt_src} = rd_data;
				state_d   = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == FSM_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			qdl_q <= deadline;
		end
		if (done) begin
			best_idx_q <= idx_w[NUM_SLOTS];
			best_dl_q  <= link_w[NUM_SLOTS].best_dl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q    <= nxt_found;
			out_slot_q <= nxt_slot;
			out_dl_q   <= nxt_dl;
			out_src_q  <= nxt_src;
			out_dst_q  <= nxt_dst;
			out_len_q  <= nxt_len;
			out_dir_q  <= nxt_dir;
			sync_q     <= nxt_sync;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign out_slot       = out_slot_q;
	assign out_deadline   = out_dl_q;
	assign out_src_addr   = out_src_q;
	assign out_dst_addr   = out_dst_q;
	assign out_byte_count = out_len_q;
	assign out_direction  = out_dir_q;
	assign sync_pending   = sync_q;

	a_scan_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN) |-> !out_valid_q)
		else $error("result register busy during a search");

	a_run_on_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> (req_q == REQ_DISPATCH))
		else $error("running mark outside a dispatch");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_READ) |=> (out_valid_q && found_q))
		else $error("descriptor read did not produce a dispatch result");

	a_found_not_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q) |-> !sync_q)
		else $error("dispatch and sync answer in one result");

endmodule

`default_nettype wire

[sim/edcs_checker.sv]
`timescale 1ns / 1ps

module edcs_checker #(
	parameter int NUM_SLOTS = edcs_pkg::NUM_SLOTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_stall,
	input  wire [1:0]                    req_type,
	input  wire [edcs_pkg::SLOT_W-1:0]   slot,
	input  wire [edcs_pkg::DL_W-1:0]     deadline,
	input  wire [edcs_pkg::ADDR_W-1:0]   src_addr,
	input  wire [edcs_pkg::ADDR_W-1:0]   dst_addr,
	input  wire [edcs_pkg::LEN_W-1:0]    byte_count,
	input  wire [edcs_pkg::DIR_W-1:0]    direction,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire                          found,
	input  wire [edcs_pkg::SLOT_W-1:0]   out_slot,
	input  wire [edcs_pkg::DL_W-1:0]     out_deadline,
	input  wire [edcs_pkg::ADDR_W-1:0]   out_src_addr,
	input  wire [edcs_pkg::ADDR_W-1:0]   out_dst_addr,
	input  wire [edcs_pkg::LEN_W-1:0]    out_byte_count,
	input  wire [edcs_pkg::DIR_W-1:0]    out_direction,
	input  wire                          sync_pending,
	output int                           fail_count,
	output int                           in_flight
);
	import edcs_pkg::*;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [DL_W-1:0]   dl;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [LEN_W-1:0]  len;
		logic [DIR_W-1:0]  dir;
		logic              sync_hit;
	} sched_result_t;

	// shadow copy of the task table
	status_t           tbl_status [NUM_SLOTS];
	logic [DL_W-1:0]   tbl_dl     [NUM_SLOTS];
	logic [ADDR_W-1:0] tbl_src    [NUM_SLOTS];
	logic [ADDR_W-1:0] tbl_dst    [NUM_SLOTS];
	logic [LEN_W-1:0]  tbl_len    [NUM_SLOTS];
	logic [DIR_W-1:0]  tbl_dir    [NUM_SLOTS];

	sched_result_t expected_results [$];
	sched_result_t want;

	task automatic report_mismatch(input string msg);
		if (fail_count < 200)
			$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic sched_result_t schedule_request(
		input req_t              req,
		input logic [SLOT_W-1:0] idx,
		input logic [DL_W-1:0]   dl,
		input logic [ADDR_W-1:0] src,
		input logic [ADDR_W-1:0] dst,
		input logic [LEN_W-1:0]  len,
		input logic [DIR_W-1:0]  dir
	);
		sched_result_t   r;
		logic            have;
		int              best;
		logic [DL_W-1:0] best_dl;
		r       = '0;
		have    = 1'b0;
		best    = 0;
		best_dl = '0;
		case (req)
			REQ_POST: begin
				if (idx < NUM_SLOTS) begin
					tbl_dl[idx]     = dl;
					tbl_src[idx]    = src;
					tbl_dst[idx]    = dst;
					tbl_len[idx]    = len;
					tbl_dir[idx]    = dir;
					tbl_status[idx] = ST_PENDING;
				end
			end
			REQ_DISPATCH: begin
				// strict less-than keeps the lowest index on ties
				for (int t = 0; t < NUM_SLOTS; t++) begin
					if (tbl_status[t] == ST_PENDING && (!have || tbl_dl[t] < best_dl)) begin
						have    = 1'b1;
						best    = t;
						best_dl = tbl_dl[t];
					end
				end
				if (have) begin
					tbl_status[best] = ST_RUNNING;
					r.found = 1'b1;
					r.slot  = SLOT_W'(best);
					r.dl    = best_dl;
					r.src   = tbl_src[best];
					r.dst   = tbl_dst[best];
					r.len   = tbl_len[best];
					r.dir   = tbl_dir[best];
				end
			end
			REQ_COMPLETE: begin
				if (idx < NUM_SLOTS && tbl_status[idx] != ST_FREE)
					tbl_status[idx] = ST_DONE;
			end
			default: begin
				for (int t = 0; t < NUM_SLOTS; t++) begin
					if ((tbl_status[t] == ST_PENDING || tbl_status[t] == ST_RUNNING) &&
					    tbl_dl[t] == dl)
						r.sync_hit = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_SLOTS; t++)
				tbl_status[t] = ST_FREE;
			expected_results.delete();
			fail_count = 0;
			in_flight  = 0;
		end else begin
			// result transfer first: it always belongs to an earlier request
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_results.pop_front();
					if (found !== want.found)
						report_mismatch($sformatf("found %0b, want %0b", found, want.found));
					if (out_slot !== want.slot)
						report_mismatch($sformatf("out_slot %0d, want %0d", out_slot, want.slot));
					if (out_deadline !== want.dl)
						report_mismatch($sformatf("out_deadline %0d, want %0d",
							out_deadline, want.dl));
					if (out_src_addr !== want.src)
						report_mismatch($sformatf("out_src_addr %h, want %h",
							out_src_addr, want.src));
					if (out_dst_addr !== want.dst)
						report_mismatch($sformatf("out_dst_addr %h, want %h",
							out_dst_addr, want.dst));
					if (out_byte_count !== want.len)
						report_mismatch($sformatf("out_byte_count %h, want %h",
							out_byte_count, want.len));
					if (out_direction !== want.dir)
						report_mismatch($sformatf("out_direction %0d, want %0d",
							out_direction, want.dir));
					if (sync_pending !== want.sync_hit)
						report_mismatch($sformatf("sync_pending %0b, want %0b",
							sync_pending, want.sync_hit));
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(schedule_request(req_t'(req_type), slot, deadline,
					src_addr, dst_addr, byte_count, direction));
			in_flight = expected_results.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import edcs_pkg::*;

	localparam int NSLOTS = NUM_SLOTS_DEF;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              out_stall;
	logic [1:0]        req_type;
	logic [SLOT_W-1:0] slot;
	logic [DL_W-1:0]   deadline;
	logic [ADDR_W-1:0] src_addr;
	logic [ADDR_W-1:0] dst_addr;
	logic [LEN_W-1:0]  byte_count;
	logic [DIR_W-1:0]  direction;

	wire               in_stall;
	wire               out_valid;
	wire               found;
	wire [SLOT_W-1:0]  out_slot;
	wire [DL_W-1:0]    out_deadline;
	wire [ADDR_W-1:0]  out_src_addr;
	wire [ADDR_W-1:0]  out_dst_addr;
	wire [LEN_W-1:0]   out_byte_count;
	wire [DIR_W-1:0]   out_direction;
	wire               sync_pending;

	int fail_count;
	int in_flight;
	bit quiet;

	always #5 clk = ~clk;

	earliest_deadline_copy_scheduler #(.NUM_SLOTS(NSLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .slot(slot), .deadline(deadline),
		.src_addr(src_addr), .dst_addr(dst_addr),
		.byte_count(byte_count), .direction(direction),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .out_slot(out_slot), .out_deadline(out_deadline),
		.out_src_addr(out_src_addr), .out_dst_addr(out_dst_addr),
		.out_byte_count(out_byte_count), .out_direction(out_direction),
		.sync_pending(sync_pending)
	);

	edcs_checker #(.NUM_SLOTS(NSLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .slot(slot), .deadline(deadline),
		.src_addr(src_addr), .dst_addr(dst_addr),
		.byte_count(byte_count), .direction(direction),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .out_slot(out_slot), .out_deadline(out_deadline),
		.out_src_addr(out_src_addr), .out_dst_addr(out_dst_addr),
		.out_byte_count(out_byte_count), .out_direction(out_direction),
		.sync_pending(sync_pending),
		.fail_count(fail_count), .in_flight(in_flight)
	);

	// one request transfer; fields change only at the falling edge
	task automatic send_req(input req_t r, input logic [SLOT_W-1:0] s,
		input logic [DL_W-1:0] d, input logic [ADDR_W-1:0] sa,
		input logic [ADDR_W-1:0] da, input logic [LEN_W-1:0] bc,
		input logic [DIR_W-1:0] dr);
		@(negedge clk);
		req_type   = r;
		slot       = s;
		deadline   = d;
		src_addr   = sa;
		dst_addr   = da;
		byte_count = bc;
		direction  = dr;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// request whose descriptor fields carry junk
	task automatic send_ctl(input req_t r, input logic [SLOT_W-1:0] s,
		input logic [DL_W-1:0] d);
		send_req(r, s, d, $urandom, $urandom, LEN_W'($urandom), DIR_W'($urandom));
	endtask

	task automatic idle_sender(input int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic logic [DL_W-1:0] pick_deadline();
		case ($urandom_range(0, 3))
			0:       return DL_W'($urandom);
			1:       return DL_W'(16'hffff - $urandom_range(0, 3));
			default: return DL_W'($urandom_range(0, 15));
		endcase
	endfunction

	task automatic send_random(input bit wellformed);
		int                w;
		req_t              r;
		logic [SLOT_W-1:0] s;
		if (!wellformed) begin
			send_req(req_t'($urandom_range(0, 3)), SLOT_W'($urandom), DL_W'($urandom),
				$urandom, $urandom, LEN_W'($urandom), DIR_W'($urandom));
		end else begin
			w = $urandom_range(0, 99);
			if (w < 35)
				r = REQ_POST;
			else if (w < 65)
				r = REQ_DISPATCH;
			else if (w < 85)
				r = REQ_COMPLETE;
			else
				r = REQ_SYNC;
			// a small slot pool makes overwrites and completes of live slots common
			s = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 23)) : SLOT_W'($urandom);
			if (r == REQ_POST)
				send_req(r, s, pick_deadline(), $urandom, $urandom, LEN_W'($urandom),
					DIR_W'($urandom));
			else
				send_ctl(r, s, pick_deadline());
		end
	endtask

	// receiver stalls in bursts, none in the final stretch
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin : stimulus
		int i;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		quiet      = 1'b0;
		req_type   = REQ_POST;
		slot       = '0;
		deadline   = '0;
		src_addr   = '0;
		dst_addr   = '0;
		byte_count = '0;
		direction  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_ctl(REQ_DISPATCH, 0, 0);
		send_ctl(REQ_SYNC, 0, 0);
		send_req(REQ_POST, 0, 16'hffff, '1, '1, '1, '1);
		send_req(REQ_POST, 127, 0, '0, '0, '0, '0);
		send_req(REQ_POST, 5, 0, 32'h12345678, 32'h9abcdef0, 31'h2aaaaaaa, 1);
		send_ctl(REQ_SYNC, 0, 0);
		send_ctl(REQ_SYNC, 0, 16'hffff);
		send_ctl(REQ_SYNC, 0, 1);
		// equal deadlines: lower slot goes first
		send_ctl(REQ_DISPATCH, 0, 0);
		send_ctl(REQ_DISPATCH, 0, 0);
		// running slots still answer sync
		send_ctl(REQ_SYNC, 0, 0);
		send_req(REQ_POST, 127, 200, 32'h55555555, 32'haaaaaaaa, 31'h55555555, 2);
		send_ctl(REQ_COMPLETE, 5, 0);
		send_ctl(REQ_SYNC, 0, 0);
		send_ctl(REQ_COMPLETE, 3, 0);
		send_req(REQ_POST, 0, 100, 32'hdeadbeef, 32'h0badf00d, 31'h00001000, 3);
		send_ctl(REQ_DISPATCH, 0, 0);
		send_ctl(REQ_COMPLETE, 0, 0);
		send_ctl(REQ_COMPLETE, 0, 0);
		send_ctl(REQ_DISPATCH, 0, 0);
		send_ctl(REQ_COMPLETE, 127, 0);
		send_ctl(REQ_DISPATCH, 0, 0);
		send_req(REQ_POST, 5, 7, 32'h00000001, 32'h80000000, 31'h40000000, 0);
		send_ctl(REQ_COMPLETE, 5, 0);
		send_ctl(REQ_DISPATCH, 0, 0);
		send_ctl(REQ_SYNC, 0, 7);

		for (i = 0; i < 550; i++) begin
			if (i == 470)
				quiet = 1'b1;
			if (i == 250) begin
				// hold off until everything in flight has drained
				idle_sender(1);
				wait (in_flight == 0);
			end
			if (!quiet && $urandom_range(0, 4) == 0)
				idle_sender($urandom_range(1, 19));
			send_random($urandom_range(0, 9) != 0);
		end

		idle_sender(1);
		wait (in_flight == 0);
		repeat (NSLOTS + 100) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
design/edcs_pkg.sv
design/edcs_cell.sv
design/edcs_desc_mem.sv
design/earliest_deadline_copy_scheduler.sv
sim/edcs_checker.sv
sim/tb_top.sv
